@@ rtl/core/wbcc_pkg.sv @@
// Types and constants shared by the write-back data cache with LL/SC.
// No dependencies; imported by wbcc_index and the top level.
package wbcc_pkg;

    localparam int ADDR_W     = 12;
    localparam int DATA_W     = 32;
    localparam int BLOCK_BYTES = 8;
    localparam int WORD_BYTES  = 4;
    localparam int OFFSET_W   = $clog2(BLOCK_BYTES);
    localparam int BLOCK_W    = ADDR_W - OFFSET_W;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_STORE,
        OP_LOAD_LINK,
        OP_STORE_COND
    } op_e;

    typedef struct packed {
        op_e                      operation;
        logic [ADDR_W-1:0]        address;
        logic signed [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     hit;
        logic                     store_success;
        logic                     wrote_back;
    } rsp_t;

endpackage

@@ rtl/core/wbcc_index.sv @@
// Backing memory index of a block's first word: (2 * block) mod MEMORY_WORDS.
// Two-stage pipeline, reciprocal multiply then multiply-back and subtract.
// Depends on wbcc_pkg.
module wbcc_index
    import wbcc_pkg::*;
#(
    parameter int MEMORY_WORDS = 1024
)
(
    input  logic                            clk,
    input  logic [BLOCK_W-1:0]              block,
    output logic [$clog2(MEMORY_WORDS)-1:0] index
);

    localparam int     XW    = BLOCK_W + 1;
    localparam int     IDX_W = $clog2(MEMORY_WORDS);
    localparam int     SHIFT = XW + IDX_W;
    localparam longint RECIP = ((longint'(1) << SHIFT) + MEMORY_WORDS - 1) / MEMORY_WORDS;
    localparam int     RW    = XW + 2;
    localparam int     PW    = XW + RW;
    localparam int     MW    = XW + 18;

    logic [XW-1:0] x;
    logic [XW-1:0] x_reg;
    logic [PW-1:0] prod_reg;
    logic [XW-1:0] quot;
    logic [MW-1:0] back;

    assign x    = {block, 1'b0};
    assign quot = XW'(prod_reg >> SHIFT);
    assign back = MW'(quot) * MW'(MEMORY_WORDS);

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(x) * PW'(RECIP);
        x_reg    <= x;
        index    <= IDX_W'(MW'(x_reg) - back);
    end

endmodule

@@ rtl/core/write_back_data_cache_clock_llsc_unit.sv @@
// Fully associative write-back cache, clock replacement, LL/SC, internal backing memory.
// Hit: lookup, then completion; no new request is taken until the result is issued.
// Miss: a clock scan of 1 to CACHE_LINES + 1 steps, then index, write-back and refill;
//   the single memory port serializes write-back and refill, two words each.
// Reset: clears lines, hand and link, then sweeps all MEMORY_WORDS words, zeroing memory.
module write_back_data_cache_clock_llsc_unit
    import wbcc_pkg::*;
#(
    parameter int CACHE_LINES  = 4,
    parameter int MEMORY_WORDS = 1024
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int HAND_W = $clog2(CACHE_LINES);
    localparam int IDX_W  = $clog2(MEMORY_WORDS);
    localparam logic [HAND_W-1:0] LAST_LINE = HAND_W'(CACHE_LINES - 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MEMORY_WORDS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_IDX0,
        ST_IDX1,
        ST_WB0,
        ST_WB1,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_DONE
    } state_e;

    state_e                state_reg;
    logic [IDX_W-1:0]      clr_cnt_reg;
    req_t                  req_reg;
    rsp_t                  result_reg;
    rsp_t                  rsp_reg;
    logic                  rsp_valid_reg;
    logic                  line_valid_reg  [CACHE_LINES];
    logic                  line_dirty_reg  [CACHE_LINES];
    logic                  line_used_reg   [CACHE_LINES];
    logic [BLOCK_W-1:0]    line_tag_reg    [CACHE_LINES];
    logic [DATA_W-1:0]     line_first_reg  [CACHE_LINES];
    logic [DATA_W-1:0]     line_second_reg [CACHE_LINES];
    logic [HAND_W-1:0]     hand_reg;
    logic [HAND_W-1:0]     victim_reg;
    logic [ADDR_W-1:0]     link_addr_reg;
    logic                  link_valid_reg;
    logic [DATA_W-1:0]     fill_first_reg;

    logic [DATA_W-1:0]     mem_q [MEMORY_WORDS];
    logic [DATA_W-1:0]     mem_rdata_reg;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_addr;
    logic [DATA_W-1:0]     mem_wdata;

    logic [BLOCK_W-1:0]    req_block;
    logic                  req_second;
    logic                  is_store;
    logic                  is_cond;
    logic                  sc_fail;
    logic                  hit_any;
    logic [HAND_W-1:0]     hit_line;
    logic [HAND_W-1:0]     hand_adv;
    logic                  rsp_free;
    logic                  victim_dirty;
    logic [IDX_W-1:0]      new_idx;
    logic [IDX_W-1:0]      new_idx1;
    logic [IDX_W-1:0]      vic_idx;
    logic [IDX_W-1:0]      vic_idx1;

    assign req_block  = req_reg.address[ADDR_W-1:OFFSET_W];
    assign req_second = |req_reg.address[OFFSET_W-1:0];
    assign is_cond    = (req_reg.operation == OP_STORE_COND);
    assign is_store   = (req_reg.operation == OP_STORE) || is_cond;
    assign sc_fail    = is_cond && !(link_valid_reg && (link_addr_reg == req_reg.address));
    assign hand_adv   = (hand_reg == LAST_LINE) ? '0 : hand_reg + 1'b1;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign victim_dirty = line_valid_reg[victim_reg] && line_dirty_reg[victim_reg];
    assign new_idx1   = (new_idx == LAST_IDX) ? '0 : new_idx + 1'b1;
    assign vic_idx1   = (vic_idx == LAST_IDX) ? '0 : vic_idx + 1'b1;

    assign req_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    wbcc_index #(.MEMORY_WORDS(MEMORY_WORDS)) u_new_index (
        .clk   (clk),
        .block (req_block),
        .index (new_idx)
    );

    wbcc_index #(.MEMORY_WORDS(MEMORY_WORDS)) u_vic_index (
        .clk   (clk),
        .block (line_tag_reg[victim_reg]),
        .index (vic_idx)
    );

    always_comb
    begin
        hit_any  = 1'b0;
        hit_line = '0;
        for (int i = CACHE_LINES - 1; i >= 0; i--)
        begin
            if (line_valid_reg[i] && (line_tag_reg[i] == req_block))
            begin
                hit_any  = 1'b1;
                hit_line = HAND_W'(i);
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = new_idx;
        mem_wdata = line_first_reg[victim_reg];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_WB0:
            begin
                mem_we    = victim_dirty;
                mem_addr  = vic_idx;
            end
            ST_WB1:
            begin
                mem_we    = victim_dirty;
                mem_addr  = vic_idx1;
                mem_wdata = line_second_reg[victim_reg];
            end
            ST_RD1:
            begin
                mem_addr  = new_idx1;
            end
            default:
            begin
                mem_addr  = new_idx;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_q[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem_q[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            req_reg        <= '0;
            result_reg     <= '0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            hand_reg       <= '0;
            victim_reg     <= '0;
            link_addr_reg  <= '0;
            link_valid_reg <= 1'b0;
            fill_first_reg <= '0;
            for (int i = 0; i < CACHE_LINES; i++)
            begin
                line_valid_reg[i]  <= 1'b0;
                line_dirty_reg[i]  <= 1'b0;
                line_used_reg[i]   <= 1'b0;
                line_tag_reg[i]    <= '0;
                line_first_reg[i]  <= '0;
                line_second_reg[i] <= '0;
            end
        end
        else
        begin
            if ((state_reg == ST_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == LAST_IDX)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        req_reg    <= req;
                        result_reg <= '0;
                        state_reg  <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (sc_fail)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        if (req_reg.operation == OP_LOAD_LINK)
                        begin
                            link_addr_reg  <= req_reg.address;
                            link_valid_reg <= 1'b1;
                        end
                        if (hit_any)
                        begin
                            line_used_reg[hit_line] <= 1'b1;
                            result_reg.hit          <= 1'b1;
                            if (is_store)
                            begin
                                if (req_second)
                                begin
                                    line_second_reg[hit_line] <= req_reg.write_data;
                                end
                                else
                                begin
                                    line_first_reg[hit_line] <= req_reg.write_data;
                                end
                                line_dirty_reg[hit_line] <= 1'b1;
                                result_reg.store_success <= is_cond;
                            end
                            else
                            begin
                                result_reg.read_data <= req_second ? line_second_reg[hit_line]
                                                                   : line_first_reg[hit_line];
                            end
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    hand_reg <= hand_adv;
                    if (line_used_reg[hand_reg])
                    begin
                        line_used_reg[hand_reg] <= 1'b0;
                    end
                    else
                    begin
                        victim_reg <= hand_reg;
                        state_reg  <= ST_IDX0;
                    end
                end
                ST_IDX0:
                begin
                    state_reg <= ST_IDX1;
                end
                ST_IDX1:
                begin
                    state_reg <= ST_WB0;
                end
                ST_WB0:
                begin
                    state_reg <= ST_WB1;
                end
                ST_WB1:
                begin
                    state_reg <= ST_RD0;
                end
                ST_RD0:
                begin
                    state_reg <= ST_RD1;
                end
                ST_RD1:
                begin
                    fill_first_reg <= mem_rdata_reg;
                    state_reg      <= ST_RD2;
                end
                ST_RD2:
                begin
                    line_valid_reg[victim_reg] <= 1'b1;
                    line_used_reg[victim_reg]  <= 1'b1;
                    line_tag_reg[victim_reg]   <= req_block;
                    result_reg.wrote_back      <= victim_dirty;
                    if (is_store)
                    begin
                        line_first_reg[victim_reg]  <= req_second ? fill_first_reg
                                                                  : req_reg.write_data;
                        line_second_reg[victim_reg] <= req_second ? req_reg.write_data
                                                                  : mem_rdata_reg;
                        line_dirty_reg[victim_reg]  <= 1'b1;
                        result_reg.store_success    <= is_cond;
                    end
                    else
                    begin
                        line_first_reg[victim_reg]  <= fill_first_reg;
                        line_second_reg[victim_reg] <= mem_rdata_reg;
                        line_dirty_reg[victim_reg]  <= 1'b0;
                        result_reg.read_data        <= req_second ? mem_rdata_reg
                                                                  : fill_first_reg;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (rsp_free)
                    begin
                        rsp_reg       <= result_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_accept_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("transfer taken while previous item still in flight");

    a_writeback_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.wrote_back |-> !rsp.hit)
        else $error("write-back reported on a hit");

    a_store_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.store_success |-> (rsp.read_data == '0) && !rsp.wrote_back || 
        rsp_valid && rsp.store_success && (rsp.read_data == '0))
        else $error("store reported load data");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside completion");

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) && (clr_cnt_reg != LAST_IDX) |=> req_stall)
        else $error("transfer possible during memory clear");

endmodule
